>>> rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, constants and the per-scan update function for the button
// debounce and auto-repeat block.
// ----------------------------------------------------------------------------
package bda_pkg;

  // Widths fixed by the stream fields and the hold counter.
  localparam int unsigned IdxW       = 2;
  localparam int unsigned CountW     = 16;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 8;
  localparam logic [CountW-1:0] HoldLimitReset = 16'h0040;
  localparam logic [CountW-1:0] CountMax       = 16'hFFFF;

  // Debounce phase of one button.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2,
    PH_REPEAT  = 2'd3
  } bda_phase_e;

  // One entry of the per-button state memory.
  typedef struct packed {
    bda_phase_e        phase;
    logic [CountW-1:0] count;
  } bda_entry_t;

  // Event flags raised by one scan.
  typedef struct packed {
    logic rep_end;
    logic rep;
    logic release_ev;
    logic press;
  } bda_flags_t;

  // Result of one scan: the updated entry and its event flags.
  typedef struct packed {
    bda_entry_t entry;
    bda_flags_t flags;
  } bda_step_t;

  localparam bda_entry_t EntryReset = '{phase: PH_IDLE, count: '0};

  // Advance one button's state by one scan.
  function automatic bda_step_t bda_step(input bda_entry_t cur,
                                         input logic pressed,
                                         input logic [CountW-1:0] limit);
    bda_step_t         res;
    logic [CountW-1:0] cnt_inc;
    res.entry = cur;
    res.flags = '0;
    cnt_inc   = (cur.count != CountMax) ? cur.count + 1'b1 : cur.count;
    unique case (cur.phase)
      PH_IDLE: begin
        if (pressed) begin
          res.entry.phase = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (pressed) begin
          res.entry.phase = PH_HELD;
          res.flags.press = 1'b1;
        end else begin
          res.entry.phase = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (pressed) begin
          if (cnt_inc > limit) begin
            res.entry.phase = PH_REPEAT;
            res.entry.count = '0;
          end else begin
            res.entry.count = cnt_inc;
          end
        end else begin
          res.entry.phase      = PH_IDLE;
          res.entry.count      = '0;
          res.flags.release_ev = 1'b1;
        end
      end
      PH_REPEAT: begin
        res.flags.rep = 1'b1;
        if (!pressed) begin
          res.entry.phase   = PH_IDLE;
          res.flags.rep_end = 1'b1;
        end
      end
      default: begin
        res.entry = cur;
      end
    endcase
    return res;
  endfunction

endpackage

>>> rtl/bda_state_mem.sv
// ----------------------------------------------------------------------------
// bda_state_mem
// Per-button state memory with one registered read port and one write port.
// Valid bits make entries that were never written read as the reset state.
// ----------------------------------------------------------------------------
module bda_state_mem
  import bda_pkg::*;
#(
  parameter int unsigned Depth = 3,
  parameter int unsigned AddrW = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output bda_entry_t       rd_entry_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  bda_entry_t       wr_entry_i
);

  bda_entry_t       mem [Depth];
  logic [Depth-1:0] valid_q;
  bda_entry_t       rd_data_q;
  logic             rd_valid_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  // Entry valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read port; holds its data until the next read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : EntryReset;

endmodule

>>> rtl/button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounces scanned button levels and raises press, release, auto-repeat
// and repeat-end events, with per-button state held in a small memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one beat is one scan of one button, giving the
//   button index and its raw active-low pin level. Output stream (m_axis):
//   exactly one result beat per scan, in scan order, carrying the index and
//   the four event flags. cfg_we_i writes hold_limit; write it only while
//   no scan is in flight.
//   Throughput: one scan per cycle unless the output stalls. The state
//   memory is read when a scan is accepted and written back as it leaves
//   the update stage; a forwarding register covers two back-to-back scans
//   of the same button. Each scan passes the update stage, then the output
//   register, before it leaves as a result beat.
//   Reset: all buttons return to idle with a zero hold count (through the
//   memory's valid bits, no clearing pass) and hold_limit returns to 0x40.
//   Stall: while m_axis_tready_i is low, one result waits in the output
//   register and one more scan waits in the update stage; s_axis_tready_o
//   then drops until the output moves.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat
  import bda_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: [1:0] button_index, [2] pin_level, [7:3] zero
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tdata: [1:0] event_button, [2] press_event, [3] release_event,
  //        [4] repeat_event, [5] repeat_end_event, [7:6] zero
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i
);

  localparam int unsigned AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [4:0]  NumBtn = 5'(NUM_BUTTONS);

  // Hold limit register.
  logic [CountW-1:0] hold_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_limit_q <= HoldLimitReset;
    end else if (cfg_we_i) begin
      hold_limit_q <= cfg_wdata_i;
    end
  end

  // Input decode.
  logic [IdxW-1:0]    in_idx;
  logic               in_pressed;
  logic [AddrW+1:0]   in_idx_wide;
  logic [AddrW-1:0]   in_addr;
  logic               in_fire;
  logic               in_in_range;

  assign in_idx      = s_axis_tdata_i[IdxW-1:0];
  assign in_pressed  = ~s_axis_tdata_i[IdxW];
  assign in_idx_wide = {{AddrW{1'b0}}, in_idx};
  assign in_addr     = in_idx_wide[AddrW-1:0];
  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_in_range = ({3'b000, in_idx} < NumBtn);

  // Update stage and output register handshake.
  logic             s1_valid_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_pressed_q;
  logic             s1_adv;
  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  assign s1_adv          = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_idx_q     <= in_idx;
      s1_addr_q    <= in_addr;
      s1_pressed_q <= in_pressed;
    end
  end

  // State memory and write-back forwarding.
  bda_entry_t mem_rd_entry;
  bda_entry_t cur_entry;
  bda_step_t  step;
  logic       s1_in_range;
  logic       wr_en;
  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  bda_entry_t       fwd_entry_q;

  assign s1_in_range = ({3'b000, s1_idx_q} < NumBtn);
  assign wr_en       = s1_adv && s1_in_range;

  // Scans of an index without a button do not touch the memory.
  bda_state_mem #(
    .Depth (NUM_BUTTONS),
    .AddrW (AddrW)
  ) u_state_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire && in_in_range),
    .rd_addr_i  (in_addr),
    .rd_entry_o (mem_rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_addr_q),
    .wr_entry_i (step.entry)
  );

  // Last write is kept so that a read issued in the same cycle sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q  <= s1_addr_q;
      fwd_entry_q <= step.entry;
    end
  end

  assign cur_entry = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_entry_q
                                                                : mem_rd_entry;

  // Per-scan update; out-of-range scans leave the flags clear.
  always_comb begin
    step = bda_step(cur_entry, s1_pressed_q, hold_limit_q);
    if (!s1_in_range) begin
      step.flags = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {2'b00, step.flags.rep_end, step.flags.rep,
                   step.flags.release_ev, step.flags.press, s1_idx_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Assertions.
  a_count_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_in_range && (cur_entry.phase != PH_HELD)
      |-> (cur_entry.count == '0))
    else $error("hold count nonzero outside the held phase");

  a_rep_end_implies_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && step.flags.rep_end |-> step.flags.rep)
    else $error("repeat end raised without repeat");

  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(step.flags.press && step.flags.release_ev))
    else $error("press and release raised together");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_idx_q))
    else $error("update stage lost a stalled scan");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({3'b000, s1_idx_q} < NumBtn))
    else $error("state write for a nonexistent button");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and auto-repeat block. Scans
// go in on the input stream; checked table rows give their own expected
// beat; the others come from a behavioral debounce model kept in step with
// the block. A short directed table comes first, then random press and
// release runs under several hold limits, then a held button at the top
// limit that never repeats until the limit is lowered below its count.
// Both stream sides idle at random, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top
  import bda_pkg::*;
();

  localparam int NumButtons = 3;
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int TopLimitScans = 40;

  // Event flag patterns, {repeat_end, repeat, release, press}.
  localparam logic [3:0] EV_NONE       = 4'b0000;
  localparam logic [3:0] EV_PRESS      = 4'b0001;
  localparam logic [3:0] EV_RELEASE    = 4'b0010;
  localparam logic [3:0] EV_REPEAT     = 4'b0100;
  localparam logic [3:0] EV_REPEAT_END = 4'b1100;

  // One output beat, laid out as on m_axis_tdata_o.
  typedef struct packed {
    logic [1:0] pad;
    logic       rep_end;
    logic       rep;
    logic       rel;
    logic       press;
    logic [1:0] btn;
  } scan_result_t;

  typedef enum logic [1:0] {
    ROW_SCAN,
    ROW_CHECKED,
    ROW_LIMIT
  } row_kind_e;

  // One row of the directed stimulus table.
  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        idx;
    logic              pin;
    logic [3:0]        flags;
    logic [CountW-1:0] value;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we = 1'b0;
  logic [CountW-1:0]   cfg_wdata = '0;

  // Debounce model state and configuration.
  bda_phase_e        btn_phase [NumButtons];
  logic [CountW-1:0] btn_count [NumButtons];
  logic [CountW-1:0] hold_limit_q;

  scan_result_t expected_events [$];
  stim_row_t    directed_rows [$];
  int           mismatch_count = 0;
  int           scans_in = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  scan_result_t got_beat;
  scan_result_t want_beat;

  // Random run generator state, per button.
  bit  run_pressed [NumButtons];
  int  run_left [NumButtons];
  int  focus_btn = 0;

  button_debounce_autorepeat #(
    .NUM_BUTTONS(NumButtons)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance one button of the model by one scan and return its event beat.
  task automatic debounce_predict(input logic [1:0] idx, input logic pin,
                                  output scan_result_t res);
    logic pressed;
    pressed = !pin;
    res = '0;
    res.btn = idx;
    if (idx < NumButtons) begin
      case (btn_phase[idx])
        PH_IDLE: begin
          if (pressed) btn_phase[idx] = PH_CONFIRM;
        end
        PH_CONFIRM: begin
          if (pressed) begin
            btn_phase[idx] = PH_HELD;
            res.press = 1'b1;
          end else begin
            btn_phase[idx] = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (pressed) begin
            if (btn_count[idx] != CountMax) btn_count[idx] = btn_count[idx] + 1'b1;
            if (btn_count[idx] > hold_limit_q) begin
              btn_phase[idx] = PH_REPEAT;
              btn_count[idx] = '0;
            end
          end else begin
            btn_phase[idx] = PH_IDLE;
            btn_count[idx] = '0;
            res.rel = 1'b1;
          end
        end
        default: begin
          res.rep = 1'b1;
          if (!pressed) begin
            btn_phase[idx] = PH_IDLE;
            res.rep_end = 1'b1;
          end
        end
      endcase
    end
  endtask

  // Offer one scan and wait for its beat to be taken; returns the prediction.
  task automatic send_scan(input logic [1:0] idx, input logic pin,
                           output scan_result_t predicted);
    s_valid <= 1'b1;
    s_data  <= {5'b00000, pin, idx};
    do @(posedge clk); while (!s_axis_tready_o);
    scans_in++;
    debounce_predict(idx, pin, predicted);
  endtask

  // Sender pacing: bursts of random length with random gaps between them.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
      burst_left = ($urandom_range(9, 0) == 0) ? int'($urandom_range(80, 30))
                                                : int'($urandom_range(24, 0));
    end
  endtask

  // Write hold_limit once every expected beat has arrived.
  task automatic write_limit(input logic [CountW-1:0] value);
    s_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    hold_limit_q = value;
  endtask

  function automatic stim_row_t stim_row(input row_kind_e kind, input logic [1:0] idx,
                                         input logic pin, input logic [3:0] flags,
                                         input logic [CountW-1:0] value);
    stim_row_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.pin   = pin;
    r.flags = flags;
    r.value = value;
    return r;
  endfunction

  // Random scans: mostly press and release runs on a focus button, with
  // scans of the other buttons, of the missing index and of glitches mixed in.
  task automatic run_random(input int count);
    scan_result_t predicted;
    logic [1:0]   idx;
    logic         pin;
    int           pick;
    int           run;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99, 0) < 5) focus_btn = int'($urandom_range(NumButtons - 1, 0));
      pick = int'($urandom_range(99, 0));
      if (pick < 60) idx = 2'(focus_btn);
      else if (pick < 92) idx = 2'($urandom_range(NumButtons - 1, 0));
      else idx = 2'd3;
      if (idx >= NumButtons) begin
        pin = 1'($urandom_range(1, 0));
      end else begin
        if (run_left[idx] == 0) begin
          run_pressed[idx] = !run_pressed[idx];
          if (!run_pressed[idx]) begin
            run = int'($urandom_range(4, 1));
          end else if ($urandom_range(1, 0) == 1) begin
            run = int'(hold_limit_q) + int'($urandom_range(8, 2));
            if (run > 200) run = 200;
          end else begin
            run = int'($urandom_range(5, 1));
          end
          run_left[idx] = run;
        end
        run_left[idx]--;
        pin = !run_pressed[idx];
        if ($urandom_range(99, 0) < 2) pin = !pin;
      end
      send_scan(idx, pin, predicted);
      expected_events.push_back(predicted);
      pace();
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    mismatch_count++;
  endtask

  // Output monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_beat = m_axis_tdata_o;
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected beat", int'(got_beat), -1);
      end else begin
        want_beat = expected_events.pop_front();
        if (got_beat.btn !== want_beat.btn)
          report_mismatch("event_button", int'(got_beat.btn), int'(want_beat.btn));
        if (got_beat.press !== want_beat.press)
          report_mismatch("press_event", int'(got_beat.press), int'(want_beat.press));
        if (got_beat.rel !== want_beat.rel)
          report_mismatch("release_event", int'(got_beat.rel), int'(want_beat.rel));
        if (got_beat.rep !== want_beat.rep)
          report_mismatch("repeat_event", int'(got_beat.rep), int'(want_beat.rep));
        if (got_beat.rep_end !== want_beat.rep_end)
          report_mismatch("repeat_end_event", int'(got_beat.rep_end),
                          int'(want_beat.rep_end));
        if (got_beat.pad !== want_beat.pad)
          report_mismatch("tdata padding", int'(got_beat.pad), int'(want_beat.pad));
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL button_debounce_autorepeat");
        $finish;
      end
    end
  end

  // Receiver: runs of random stall density, and one long hold-off while the
  // sender keeps offering scans.
  initial begin
    int run_len;
    int stall_pct;
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len = int'($urandom_range(40, 1));
      case ($urandom_range(3, 0))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (run_len) begin
        @(posedge clk);
        m_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
      if (!held_off && scans_in >= 150) begin
        @(posedge clk);
        m_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        held_off = 1'b1;
      end
    end
  end

  // Main stimulus.
  initial begin
    scan_result_t predicted;
    scan_result_t typed;
    stim_row_t    row;

    for (int b = 0; b < NumButtons; b++) begin
      btn_phase[b]   = PH_IDLE;
      btn_count[b]   = '0;
      run_pressed[b] = 1'b0;
      run_left[b]    = 0;
    end
    hold_limit_q = HoldLimitReset;

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed table, starting from the reset hold limit.
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd3, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b1, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b1, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b0, EV_PRESS, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd0, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b1, EV_RELEASE, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd1, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd2, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd1, 1'b0, EV_PRESS, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd2, 1'b0, EV_PRESS, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd2, 1'b1, EV_RELEASE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd1, 1'b1, EV_RELEASE, '0));
    // Lowest hold limit: the first held scan already switches to repeat.
    directed_rows.push_back(stim_row(ROW_LIMIT, 2'd0, 1'b1, EV_NONE, 16'd0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd0, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b0, EV_PRESS, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd0, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b0, EV_REPEAT, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b0, EV_REPEAT, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b1, EV_REPEAT_END, '0));
    directed_rows.push_back(stim_row(ROW_CHECKED, 2'd0, 1'b1, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_LIMIT, 2'd0, 1'b1, EV_NONE, 16'd1));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd2, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd2, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd2, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd2, 1'b0, EV_NONE, '0));
    directed_rows.push_back(stim_row(ROW_SCAN, 2'd2, 1'b1, EV_NONE, '0));

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_LIMIT) begin
        write_limit(row.value);
      end else begin
        send_scan(row.idx, row.pin, predicted);
        if (row.kind == ROW_CHECKED) begin
          typed = '0;
          typed.btn = row.idx;
          {typed.rep_end, typed.rep, typed.rel, typed.press} = row.flags;
          expected_events.push_back(typed);
        end else begin
          expected_events.push_back(predicted);
        end
        pace();
      end
    end

    // Random runs under several hold limits.
    write_limit(16'd0);
    run_random(100);
    write_limit(16'($urandom_range(12, 2)));
    run_random(120);
    write_limit(HoldLimitReset);
    run_random(140);
    write_limit(16'd1);
    run_random(80);
    write_limit(16'($urandom_range(20, 0)));
    run_random(100);

    // Long hold at the top limit: the count never exceeds it, so no repeat.
    write_limit(16'hFFFF);
    for (int k = 0; k < TopLimitScans; k++) begin
      send_scan(2'd1, 1'b0, predicted);
      expected_events.push_back(predicted);
    end
    // A limit below the held count switches to repeat on the next scan.
    write_limit(16'd1);
    send_scan(2'd1, 1'b0, predicted);
    expected_events.push_back(predicted);
    send_scan(2'd1, 1'b0, predicted);
    expected_events.push_back(predicted);
    send_scan(2'd1, 1'b1, predicted);
    expected_events.push_back(predicted);
    s_valid <= 1'b0;

    // Drain, then keep watching for any stray beat before the verdict.
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS button_debounce_autorepeat");
    end else begin
      $display("FAIL button_debounce_autorepeat");
    end
    $finish;
  end

endmodule
